[src/ugnq_pkg.sv]
package ugnq_pkg;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MOVE   = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_EDGE = 2'd2;

  // register reset values
  localparam logic [6:0]  ROWS_RESET = 7'd8;
  localparam logic [6:0]  COLS_RESET = 7'd8;
  localparam logic [15:0] EDGE_RESET = 16'd128;

  // most query results reported for one query
  localparam int RES_CAP = 64;

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_SWEEP   = 24'h000002,
    S_SEND    = 24'h000004,
    S_DIV_LD  = 24'h000008,
    S_DIV     = 24'h000010,
    S_CELL    = 24'h000020,
    S_SL_RD   = 24'h000040,
    S_SL_CHK  = 24'h000080,
    S_UNLINK  = 24'h000100,
    S_LT_RD   = 24'h000200,
    S_LT_WR   = 24'h000400,
    S_LT_LINK = 24'h000800,
    S_Q_R2    = 24'h001000,
    S_Q_SQ    = 24'h002000,
    S_Q_RD    = 24'h004000,
    S_Q_HEAD  = 24'h008000,
    S_O_RD    = 24'h010000,
    S_O_DX    = 24'h020000,
    S_O_M1    = 24'h040000,
    S_O_M2    = 24'h080000,
    S_O_CMP   = 24'h100000,
    S_O_ADV   = 24'h200000,
    S_C_ADV   = 24'h400000,
    S_Q_END   = 24'h800000
  } state_t;

endpackage

[src/uniform_grid_neighbor_query_unit.sv]
// Uniform grid neighbor query unit.
// Input channel (in_valid/in_ready) takes one operation: insert, remove, move,
// radius query or clear. Output channel (out_valid/out_ready) returns result
// transactions; last marks the final result of an operation. The config
// channel (cfg_valid/cfg_ready) is always ready and writes grid_rows,
// grid_cols or cell_edge by index; writes do not rebin stored objects.
// One operation is worked at a time; in_ready is high only when idle.
// Cell lookup uses one shared restoring divider with a quotient of
// DW = max(COORD_BITS,16)+1 bits: insert/move do two divisions, a query four.
// Clear and reset run a clearing pass over all MAX_ROWS*MAX_COLS entries of
// the cell head/tail memories, during which in_ready is low.
// Results sit in an output register; while the receiver stalls the unit
// holds in the current step, and the last result of an operation still
// lets the next operation be accepted.
module uniform_grid_neighbor_query_unit #(
  parameter int MAX_OBJECTS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [5:0]  object_id,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] search_radius,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  found_id,
  output logic [11:0] cell_number,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ugnq_pkg::*;

  localparam int SW     = $clog2(MAX_OBJECTS);
  localparam int LW     = $clog2(MAX_OBJECTS + 1);
  localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int CCW    = $clog2(MAX_COLS + 1);
  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int CLW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CBW    = COORD_BITS;
  localparam int MW     = (CBW > 16) ? CBW : 16;
  localparam int DW     = MW + 1;
  localparam int DCW    = $clog2(DW + 1);
  localparam int PW     = RIW + CCW + 1;
  localparam int PRW    = 2 * MW;
  localparam logic [LW-1:0] NIL = LW'(MAX_OBJECTS);

  // configuration registers
  logic [6:0]  grid_rows, grid_cols;
  logic [15:0] cell_edge;

  // control
  state_t state, ret_state;
  logic [2:0] op_r;
  logic [5:0] id_r;
  logic [SW-1:0] sidx;
  logic [CBW-1:0] x_r, y_r;
  logic [15:0] r_r;
  logic slot_valid [MAX_OBJECTS];
  logic [CLW-1:0] sw_cnt;
  logic sweep_send;

  // pending result
  logic [5:0] res_id;
  logic [CLW-1:0] res_cell;
  logic [1:0] res_st;
  logic res_last;

  // divider
  logic [1:0] div_idx, div_last;
  logic [DCW-1:0] div_cnt;
  logic [15:0] div_rem;
  logic [DW-1:0] div_quo;
  logic [RIW-1:0] row0, row1, row_q;
  logic [CIW-1:0] col0, col1, col_q;
  logic [CLW-1:0] cell_r;

  // distance test
  logic [PRW-1:0] prod, acc, r2;
  logic [CBW-1:0] dx, dy;
  logic [LW-1:0] o_r;
  logic [SW-1:0] cur_o;
  logic [6:0] n_match;
  logic pend_v;
  logic [SW-1:0] pend_id;
  logic [CLW-1:0] pend_cell;

  // memories and registered read data
  logic [CBW-1:0] mem_x [MAX_OBJECTS];
  logic [CBW-1:0] mem_y [MAX_OBJECTS];
  logic [CLW-1:0] mem_cell [MAX_OBJECTS];
  logic [LW-1:0] mem_next [MAX_OBJECTS];
  logic [LW-1:0] mem_prev [MAX_OBJECTS];
  logic [LW-1:0] mem_head [NCELLS];
  logic [LW-1:0] mem_tail [NCELLS];
  logic [CBW-1:0] rd_x, rd_y;
  logic [CLW-1:0] rd_cell;
  logic [LW-1:0] rd_next, rd_prev, rd_head, rd_tail;

  function automatic logic [CLW-1:0] cell_of(input logic [RIW-1:0] r,
                                             input logic [CIW-1:0] c,
                                             input logic [CCW-1:0] n);
    logic [PW-1:0] t;
    t = PW'(r) * PW'(n) + PW'(c);
    return CLW'(t);
  endfunction

  // effective register values
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic [15:0] edge_eff;
  always_comb begin
    if (grid_rows == 7'd0) rows_eff = RCW'(1);
    else if (32'(grid_rows) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
    else rows_eff = RCW'(grid_rows);
    if (grid_cols == 7'd0) cols_eff = CCW'(1);
    else if (32'(grid_cols) > MAX_COLS) cols_eff = CCW'(MAX_COLS);
    else cols_eff = CCW'(grid_cols);
    edge_eff = (cell_edge == 16'd0) ? 16'd1 : cell_edge;
  end

  // input decode
  logic in_rng, present;
  assign in_rng  = 32'(object_id) < MAX_OBJECTS;
  assign present = in_rng && slot_valid[SW'(object_id)];

  // divider datapath
  logic [DW-1:0] y_lo, y_hi, x_lo, x_hi, dividend;
  logic [16:0] div_rs, div_sub;
  logic div_ge;
  logic [DW-1:0] q_fin, q_row, q_col;
  always_comb begin
    y_lo = (DW'(y_r) > DW'(r_r)) ? DW'(y_r) - DW'(r_r) : '0;
    x_lo = (DW'(x_r) > DW'(r_r)) ? DW'(x_r) - DW'(r_r) : '0;
    y_hi = DW'(y_r) + DW'(r_r);
    x_hi = DW'(x_r) + DW'(r_r);
    case (div_idx)
      2'd0:    dividend = y_lo;
      2'd1:    dividend = x_lo;
      2'd2:    dividend = y_hi;
      default: dividend = x_hi;
    endcase
    div_rs  = {div_rem, div_quo[DW-1]};
    div_ge  = div_rs >= {1'b0, edge_eff};
    div_sub = div_rs - {1'b0, edge_eff};
    q_fin   = {div_quo[DW-2:0], div_ge};
    q_row   = (q_fin >= DW'(rows_eff)) ? DW'(rows_eff) - DW'(1) : q_fin;
    q_col   = (q_fin >= DW'(cols_eff)) ? DW'(cols_eff) - DW'(1) : q_fin;
  end

  // shared squaring multiplier operands and distance compare
  logic [MW-1:0] mul_a;
  logic [PRW:0] dist2;
  logic hit;
  logic [CLW-1:0] cell_q;
  always_comb begin
    mul_a = '0;
    if (state == S_Q_R2) mul_a = MW'(r_r);
    else if (state == S_O_M1) mul_a = MW'(dx);
    else if (state == S_O_M2) mul_a = MW'(dy);
    dist2  = {1'b0, acc} + {1'b0, prod};
    hit    = (dist2 <= {1'b0, r2}) && (n_match < 7'(RES_CAP));
    cell_q = cell_of(row_q, col_q, cols_eff);
  end

  // memory write ports
  logic xy_we, cell_we, next_we, prev_we, head_we, tail_we;
  logic [SW-1:0] next_wa, prev_wa;
  logic [LW-1:0] next_wd, prev_wd, head_wd, tail_wd;
  logic [CLW-1:0] head_wa, tail_wa;
  logic [SW-1:0] sl_ra;
  logic sl_re;
  always_comb begin
    xy_we   = (state == S_LT_WR) || (state == S_SL_CHK && op_r == OP_MOVE);
    cell_we = state == S_LT_WR;
    next_we = 1'b0; next_wa = sidx; next_wd = NIL;
    prev_we = 1'b0; prev_wa = sidx; prev_wd = rd_tail;
    head_we = 1'b0; head_wa = cell_r; head_wd = LW'(sidx);
    tail_we = 1'b0; tail_wa = cell_r; tail_wd = LW'(sidx);
    unique case (state)
      S_SWEEP: begin
        head_we = 1'b1; head_wa = sw_cnt; head_wd = NIL;
        tail_we = 1'b1; tail_wa = sw_cnt; tail_wd = NIL;
      end
      S_UNLINK: begin
        if (rd_prev != NIL) begin
          next_we = 1'b1; next_wa = rd_prev[SW-1:0]; next_wd = rd_next;
        end else begin
          head_we = 1'b1; head_wa = rd_cell; head_wd = rd_next;
        end
        if (rd_next != NIL) begin
          prev_we = 1'b1; prev_wa = rd_next[SW-1:0]; prev_wd = rd_prev;
        end else begin
          tail_we = 1'b1; tail_wa = rd_cell; tail_wd = rd_prev;
        end
      end
      S_LT_WR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        tail_we = 1'b1;
        head_we = rd_tail == NIL;
      end
      S_LT_LINK: begin
        next_we = 1'b1; next_wa = rd_tail[SW-1:0]; next_wd = LW'(sidx);
      end
      default: begin
      end
    endcase
    sl_ra = (state == S_O_RD) ? o_r[SW-1:0] : sidx;
    sl_re = (state == S_O_RD) || (state == S_SL_RD);
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (xy_we) begin
      mem_x[sidx] <= x_r;
      mem_y[sidx] <= y_r;
    end
    if (cell_we) mem_cell[sidx] <= cell_r;
    if (next_we) mem_next[next_wa] <= next_wd;
    if (prev_we) mem_prev[prev_wa] <= prev_wd;
    if (sl_re) begin
      rd_x    <= mem_x[sl_ra];
      rd_y    <= mem_y[sl_ra];
      rd_cell <= mem_cell[sl_ra];
      rd_next <= mem_next[sl_ra];
      rd_prev <= mem_prev[sl_ra];
    end
  end

  // cell head and tail memories
  always_ff @(posedge clk) begin
    if (head_we) mem_head[head_wa] <= head_wd;
    if (tail_we) mem_tail[tail_wa] <= tail_wd;
    if (state == S_Q_RD) rd_head <= mem_head[cell_q];
    if (state == S_LT_RD) rd_tail <= mem_tail[cell_r];
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    prod <= PRW'(mul_a) * PRW'(mul_a);
  end

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  // output register loads when it is empty or being drained
  logic send_go;
  assign send_go = (state == S_SEND) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      ret_state  <= S_IDLE;
      sw_cnt     <= '0;
      sweep_send <= 1'b0;
      out_valid  <= 1'b0;
      pend_v     <= 1'b0;
      n_match    <= '0;
      grid_rows  <= ROWS_RESET;
      grid_cols  <= COLS_RESET;
      cell_edge  <= EDGE_RESET;
      for (int i = 0; i < MAX_OBJECTS; i++) slot_valid[i] <= 1'b0;
    end else begin
      // configuration transaction
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROWS: grid_rows <= cfg_data[6:0];
          CFG_COLS: grid_cols <= cfg_data[6:0];
          CFG_EDGE: cell_edge <= cfg_data;
          default: begin
          end
        endcase
      end
      if (send_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op;
            id_r     <= object_id;
            sidx     <= SW'(object_id);
            x_r      <= CBW'(pos_x);
            y_r      <= CBW'(pos_y);
            r_r      <= (op == OP_QUERY) ? search_radius : 16'd0;
            div_idx  <= 2'd0;
            div_last <= (op == OP_QUERY) ? 2'd3 : 2'd1;
            res_id   <= object_id;
            res_cell <= '0;
            res_st   <= ST_ABSENT;
            res_last <= 1'b1;
            ret_state <= S_IDLE;
            unique case (op)
              OP_INSERT: begin
                if (!in_rng) state <= S_SEND;
                else if (present) state <= S_SL_RD;
                else state <= S_DIV_LD;
              end
              OP_REMOVE: state <= present ? S_SL_RD : S_SEND;
              OP_MOVE:   state <= present ? S_DIV_LD : S_SEND;
              OP_QUERY:  state <= S_DIV_LD;
              OP_CLEAR: begin
                for (int i = 0; i < MAX_OBJECTS; i++) slot_valid[i] <= 1'b0;
                sw_cnt     <= '0;
                sweep_send <= 1'b1;
                state      <= S_SWEEP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SWEEP: begin
          sw_cnt <= sw_cnt + CLW'(1);
          if (sw_cnt == CLW'(NCELLS - 1)) begin
            sweep_send <= 1'b0;
            res_id     <= 6'd0;
            res_cell   <= '0;
            res_st     <= ST_OK;
            res_last   <= 1'b1;
            ret_state  <= S_IDLE;
            state      <= sweep_send ? S_SEND : S_IDLE;
          end
        end
        S_SEND: begin
          if (send_go) begin
            found_id    <= res_id;
            cell_number <= 12'(res_cell);
            status      <= res_st;
            last        <= res_last;
            state       <= ret_state;
          end
        end
        S_DIV_LD: begin
          div_quo <= dividend;
          div_rem <= '0;
          div_cnt <= DCW'(DW - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          div_quo <= q_fin;
          div_rem <= div_ge ? div_sub[15:0] : div_rs[15:0];
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == '0) begin
            case (div_idx)
              2'd0:    row0 <= RIW'(q_row);
              2'd1:    col0 <= CIW'(q_col);
              2'd2:    row1 <= RIW'(q_row);
              default: col1 <= CIW'(q_col);
            endcase
            if (div_idx == div_last) begin
              state <= (op_r == OP_QUERY) ? S_Q_R2 : S_CELL;
            end else begin
              div_idx <= div_idx + 2'd1;
              state   <= S_DIV_LD;
            end
          end
        end
        S_CELL: begin
          cell_r <= cell_of(row0, col0, cols_eff);
          state  <= (op_r == OP_INSERT) ? S_LT_RD : S_SL_RD;
        end
        S_SL_RD: state <= S_SL_CHK;
        S_SL_CHK: begin
          res_id   <= id_r;
          res_last <= 1'b1;
          if (op_r == OP_INSERT) begin
            res_cell <= rd_cell;
            res_st   <= ST_PRESENT;
            state    <= S_SEND;
          end else if (op_r == OP_REMOVE) begin
            res_cell <= rd_cell;
            res_st   <= ST_OK;
            state    <= S_UNLINK;
          end else if (cell_r == rd_cell) begin
            res_cell <= cell_r;
            res_st   <= ST_OK;
            state    <= S_SEND;
          end else begin
            state <= S_UNLINK;
          end
        end
        S_UNLINK: begin
          if (op_r == OP_REMOVE) begin
            slot_valid[sidx] <= 1'b0;
            state <= S_SEND;
          end else begin
            state <= S_LT_RD;
          end
        end
        S_LT_RD: state <= S_LT_WR;
        S_LT_WR: begin
          slot_valid[sidx] <= 1'b1;
          res_id   <= id_r;
          res_cell <= cell_r;
          res_st   <= ST_OK;
          res_last <= 1'b1;
          state    <= (rd_tail != NIL) ? S_LT_LINK : S_SEND;
        end
        S_LT_LINK: state <= S_SEND;
        S_Q_R2: begin
          row_q   <= row0;
          col_q   <= col0;
          n_match <= '0;
          pend_v  <= 1'b0;
          state   <= S_Q_SQ;
        end
        S_Q_SQ: begin
          r2    <= prod;
          state <= S_Q_RD;
        end
        S_Q_RD: begin
          cell_r <= cell_q;
          state  <= S_Q_HEAD;
        end
        S_Q_HEAD: begin
          o_r   <= rd_head;
          state <= (rd_head == NIL) ? S_C_ADV : S_O_RD;
        end
        S_O_RD: state <= S_O_DX;
        S_O_DX: begin
          dx    <= (x_r > rd_x) ? x_r - rd_x : rd_x - x_r;
          dy    <= (y_r > rd_y) ? y_r - rd_y : rd_y - y_r;
          cur_o <= o_r[SW-1:0];
          o_r   <= rd_next;
          state <= S_O_M1;
        end
        S_O_M1: state <= S_O_M2;
        S_O_M2: begin
          acc   <= prod;
          state <= S_O_CMP;
        end
        S_O_CMP: begin
          if (hit) begin
            n_match   <= n_match + 7'd1;
            pend_v    <= 1'b1;
            pend_id   <= cur_o;
            pend_cell <= cell_r;
            if (pend_v) begin
              res_id    <= 6'(pend_id);
              res_cell  <= pend_cell;
              res_st    <= ST_OK;
              res_last  <= 1'b0;
              ret_state <= S_O_ADV;
              state     <= S_SEND;
            end else begin
              state <= S_O_ADV;
            end
          end else begin
            state <= S_O_ADV;
          end
        end
        S_O_ADV: state <= (o_r == NIL) ? S_C_ADV : S_O_RD;
        S_C_ADV: begin
          if (col_q == col1) begin
            if (row_q == row1) begin
              state <= S_Q_END;
            end else begin
              row_q <= row_q + RIW'(1);
              col_q <= col0;
              state <= S_Q_RD;
            end
          end else begin
            col_q <= col_q + CIW'(1);
            state <= S_Q_RD;
          end
        end
        S_Q_END: begin
          res_last  <= 1'b1;
          ret_state <= S_IDLE;
          if (pend_v) begin
            res_id   <= 6'(pend_id);
            res_cell <= pend_cell;
            res_st   <= ST_OK;
          end else begin
            res_id   <= 6'd0;
            res_cell <= '0;
            res_st   <= ST_NOMATCH;
          end
          state <= S_SEND;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cap: assert property (@(posedge clk) disable iff (rst)
    n_match <= 7'(RES_CAP))
    else $error("query match count beyond cap");

  a_link_new: assert property (@(posedge clk) disable iff (rst)
    (state == S_LT_WR) |-> (!slot_valid[sidx] || op_r == OP_MOVE))
    else $error("linking a slot that is already present");

  a_unlink_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK) |-> slot_valid[sidx])
    else $error("unlinking a slot that is not present");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_RD) |-> (row_q >= row0 && row_q <= row1 &&
                           col_q >= col0 && col_q <= col1))
    else $error("query scan outside its cell rectangle");

endmodule

[verif/uniform_grid_neighbor_query_unit_tb.sv]
module uniform_grid_neighbor_query_unit_tb;
  import ugnq_pkg::*;

  localparam int NSLOT = 64;
  localparam int NCELL = 4096;
  localparam int NONE = NSLOT;
  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [5:0]  id;
    logic [11:0] cnum;
    logic [1:0]  st;
    logic        lst;
  } result_t;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] r;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = OP_INSERT;
  logic [5:0]  object_id = '0;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic [15:0] search_radius = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  found_id;
  logic [11:0] cell_number;
  logic [1:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ROWS;
  logic [15:0] cfg_data = '0;

  // typed expectation travels with the payload
  bit          row_typed = 1'b0;
  result_t     row_res = '0;

  uniform_grid_neighbor_query_unit dut (.*);

  always #1 clk = ~clk;

  // grid model state
  bit              slot_on [NSLOT];
  int unsigned     slot_px [NSLOT];
  int unsigned     slot_py [NSLOT];
  int unsigned     slot_home [NSLOT];
  int unsigned     link_nxt [NSLOT];
  int unsigned     link_prv [NSLOT];
  int unsigned     cell_first [NCELL];
  int unsigned     cell_final [NCELL];
  int unsigned     rows_reg, cols_reg, edge_reg;

  result_t pending_q[$];
  int errors = 0;
  int results_got = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int idle_cycles = 0;

  // append one result to the end of a queue
  function automatic void add_res(ref result_t q[$], input result_t v);
    q.insert(q.size(), v);
  endfunction

  function automatic int unsigned rows_eff();
    if (rows_reg == 0) return 1;
    return rows_reg > 64 ? 64 : rows_reg;
  endfunction

  function automatic int unsigned cols_eff();
    if (cols_reg == 0) return 1;
    return cols_reg > 64 ? 64 : cols_reg;
  endfunction

  function automatic int unsigned edge_eff();
    return edge_reg == 0 ? 1 : edge_reg;
  endfunction

  function automatic int unsigned clamp_n(longint unsigned v, int unsigned n);
    return v >= n ? n - 1 : int'(v);
  endfunction

  function automatic int unsigned bin_of(int unsigned x, int unsigned y);
    return clamp_n(y / edge_eff(), rows_eff()) * cols_eff()
           + clamp_n(x / edge_eff(), cols_eff());
  endfunction

  function automatic void empty_grid();
    for (int i = 0; i < NSLOT; i++) slot_on[i] = 1'b0;
    for (int i = 0; i < NCELL; i++) begin
      cell_first[i] = NONE;
      cell_final[i] = NONE;
    end
  endfunction

  function automatic void append_to(int unsigned s, int unsigned c);
    slot_home[s] = c;
    link_nxt[s] = NONE;
    link_prv[s] = cell_final[c];
    if (cell_final[c] < NSLOT) link_nxt[cell_final[c]] = s;
    else cell_first[c] = s;
    cell_final[c] = s;
  endfunction

  function automatic void detach(int unsigned s);
    int unsigned c, p, n;
    c = slot_home[s];
    p = link_prv[s];
    n = link_nxt[s];
    if (p < NSLOT) link_nxt[p] = n; else cell_first[c] = n;
    if (n < NSLOT) link_prv[n] = p; else cell_final[c] = p;
  endfunction

  function automatic bit in_range(int unsigned qx, int unsigned qy, int unsigned r,
                                  int unsigned s);
    longint unsigned dx, dy;
    dx = qx > slot_px[s] ? qx - slot_px[s] : slot_px[s] - qx;
    dy = qy > slot_py[s] ? qy - slot_py[s] : slot_py[s] - qy;
    return dx * dx + dy * dy <= longint'(r) * r;
  endfunction

  // work out the results of one operation and advance the grid model
  function automatic void grid_apply(logic [2:0] o, int unsigned s, int unsigned x,
                                     int unsigned y, int unsigned r,
                                     ref result_t res_q[$]);
    int unsigned c, r0, r1, c0, c1, e, nr, nc, obj, guard;
    result_t rv;
    res_q.delete();
    case (o)
      OP_INSERT: begin
        if (slot_on[s]) begin
          add_res(res_q, '{s[5:0], slot_home[s][11:0], ST_PRESENT, 1'b1});
        end else begin
          c = bin_of(x, y);
          slot_on[s] = 1'b1;
          slot_px[s] = x;
          slot_py[s] = y;
          append_to(s, c);
          add_res(res_q, '{s[5:0], c[11:0], ST_OK, 1'b1});
        end
      end
      OP_REMOVE: begin
        if (!slot_on[s]) begin
          add_res(res_q, '{s[5:0], 12'd0, ST_ABSENT, 1'b1});
        end else begin
          c = slot_home[s];
          detach(s);
          slot_on[s] = 1'b0;
          add_res(res_q, '{s[5:0], c[11:0], ST_OK, 1'b1});
        end
      end
      OP_MOVE: begin
        if (!slot_on[s]) begin
          add_res(res_q, '{s[5:0], 12'd0, ST_ABSENT, 1'b1});
        end else begin
          c = bin_of(x, y);
          slot_px[s] = x;
          slot_py[s] = y;
          if (c != slot_home[s]) begin
            detach(s);
            append_to(s, c);
          end
          add_res(res_q, '{s[5:0], c[11:0], ST_OK, 1'b1});
        end
      end
      OP_QUERY: begin
        e = edge_eff();
        nr = rows_eff();
        nc = cols_eff();
        r0 = clamp_n((y > r ? y - r : 0) / e, nr);
        r1 = clamp_n((longint'(y) + r) / e, nr);
        c0 = clamp_n((x > r ? x - r : 0) / e, nc);
        c1 = clamp_n((longint'(x) + r) / e, nc);
        // row-major scan, list order within each cell
        for (int unsigned row = r0; row <= r1; row++) begin
          for (int unsigned col = c0; col <= c1; col++) begin
            c = row * nc + col;
            obj = cell_first[c];
            guard = 0;
            while (obj < NSLOT && guard < NSLOT) begin
              if (res_q.size() < RES_CAP && in_range(x, y, r, obj))
                add_res(res_q, '{obj[5:0], c[11:0], ST_OK, 1'b0});
              obj = link_nxt[obj];
              guard++;
            end
          end
        end
        if (res_q.size() == 0) begin
          add_res(res_q, '{6'd0, 12'd0, ST_NOMATCH, 1'b1});
        end else begin
          rv = res_q[$];
          rv.lst = 1'b1;
          res_q[$] = rv;
        end
      end
      OP_CLEAR: begin
        empty_grid();
        add_res(res_q, '{6'd0, 12'd0, ST_OK, 1'b1});
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor: score results, predict accepted operations, track config
  always @(posedge clk) begin
    result_t want, got;
    result_t new_q[$];
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_got++;
        got = '{found_id, cell_number, status, last};
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result, found_id", found_id, 0);
        end else begin
          want = pending_q.pop_front();
          if (got.id != want.id) report_mismatch("found_id", got.id, want.id);
          if (got.cnum != want.cnum) report_mismatch("cell_number", got.cnum, want.cnum);
          if (got.st != want.st) report_mismatch("status", got.st, want.st);
          if (got.lst != want.lst) report_mismatch("last", got.lst, want.lst);
        end
      end
      if (in_valid && in_ready) begin
        grid_apply(op, object_id, pos_x, pos_y, search_radius, new_q);
        if (row_typed) new_q = '{row_res};
        foreach (new_q[i]) add_res(pending_q, new_q[i]);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS: rows_reg = cfg_data[6:0];
          CFG_COLS: cols_reg = cfg_data[6:0];
          CFG_EDGE: edge_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_q.size());
      $display("uniform_grid_neighbor_query_unit_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once results are flowing
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !held && results_got >= 30) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        case ($urandom_range(0, 99)) inside
          [0:59]:  stall = 0;
          [60:89]: stall = $urandom_range(1, 3);
          [90:95]: stall = $urandom_range(10, 40);
          default: stall = 0;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    case ($urandom_range(0, 99)) inside
      [0:49]:  return 0;
      [50:89]: return $urandom_range(1, 3);
      default: return $urandom_range(10, 40);
    endcase
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_op(stim_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= row.op;
    object_id <= row.id;
    pos_x <= row.x;
    pos_y <= row.y;
    search_radius <= row.r;
    row_typed <= row.typed;
    row_res <= row.res;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (row.op == OP_QUERY) queries_sent++;
  endtask

  // drop valid, let everything drain, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(logic [15:0] rows, logic [15:0] cols, logic [15:0] edge_len);
    logic [15:0] vals [3];
    logic [1:0] idx [3];
    vals = '{rows, cols, edge_len};
    idx = '{CFG_ROWS, CFG_COLS, CFG_EDGE};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    longint unsigned span;
    span = longint'(rows_eff() > cols_eff() ? rows_eff() : cols_eff()) * edge_eff();
    if (span > 65536) span = 65536;
    if ($urandom_range(0, 99) < 80) return 16'($urandom_range(0, int'(span) - 1));
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] rand_radius();
    int unsigned e2;
    e2 = 2 * edge_eff();
    if (e2 > 65535) e2 = 65535;
    case ($urandom_range(0, 99)) inside
      [0:69]:  return 16'($urandom_range(0, e2));
      [70:89]: return 16'($urandom_range(0, 300));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    row.typed = 1'b0;
    row.res = '0;
    row.id = 6'($urandom_range(0, 63));
    row.x = rand_coord();
    row.y = rand_coord();
    row.r = 16'($urandom());
    case ($urandom_range(0, 99)) inside
      [0:34]:  row.op = OP_INSERT;
      [35:54]: row.op = OP_MOVE;
      [55:69]: row.op = OP_REMOVE;
      [70:94]: begin
        row.op = OP_QUERY;
        row.r = rand_radius();
      end
      [95:96]: row.op = OP_CLEAR;
      default: row.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endcase
    return row;
  endfunction

  initial begin
    stim_row_t table_q[$];
    stim_row_t row;
    logic [15:0] grids [7][3];
    grids = '{'{16'd8, 16'd8, 16'd128}, '{16'd1, 16'd1, 16'd1},
              '{16'd64, 16'd64, 16'd1024}, '{16'd0, 16'd0, 16'd0},
              '{16'd127, 16'd127, 16'd65535}, '{16'd64, 16'd64, 16'd1},
              '{16'd3, 16'd5, 16'd300}};
    rows_reg = ROWS_RESET;
    cols_reg = COLS_RESET;
    edge_reg = EDGE_RESET;
    empty_grid();

    // directed rows: typed results where obvious, predictor elsewhere
    table_q = '{
      '{OP_REMOVE, 6'd5, 16'd0, 16'd0, 16'd0, 1'b1, '{6'd5, 12'd0, ST_ABSENT, 1'b1}},
      '{OP_QUERY, 6'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, '{6'd0, 12'd0, ST_NOMATCH, 1'b1}},
      '{OP_INSERT, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{6'd0, 12'd0, ST_OK, 1'b1}},
      '{OP_INSERT, 6'd63, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1, '{6'd63, 12'd63, ST_OK, 1'b1}},
      '{OP_INSERT, 6'd0, 16'd9, 16'd9, 16'd0, 1'b1, '{6'd0, 12'd0, ST_PRESENT, 1'b1}},
      '{OP_INSERT, 6'd1, 16'd100, 16'd100, 16'd0, 1'b0, '0},
      '{OP_INSERT, 6'd2, 16'd130, 16'd5, 16'd0, 1'b0, '0},
      '{OP_INSERT, 6'd42, 16'h5555, 16'hAAAA, 16'd0, 1'b0, '0},
      '{OP_MOVE, 6'd1, 16'd200, 16'd300, 16'd0, 1'b0, '0},
      '{OP_MOVE, 6'd1, 16'd210, 16'd310, 16'd0, 1'b0, '0},
      '{OP_MOVE, 6'd7, 16'd1, 16'd1, 16'd0, 1'b1, '{6'd7, 12'd0, ST_ABSENT, 1'b1}},
      '{OP_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{OP_QUERY, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{OP_QUERY, 6'd0, 16'd1000, 16'd1000, 16'd1, 1'b0, '0},
      '{OP_QUERY, 6'd0, 16'hFFFF, 16'd0, 16'd10, 1'b0, '0},
      '{OP_REMOVE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{OP_SPARE_LO, 6'd3, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{OP_SPARE_HI, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{OP_QUERY, 6'd0, 16'd200, 16'd300, 16'd200, 1'b0, '0},
      '{OP_CLEAR, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{6'd0, 12'd0, ST_OK, 1'b1}},
      '{OP_QUERY, 6'd0, 16'd500, 16'd500, 16'hFFFF, 1'b1, '{6'd0, 12'd0, ST_NOMATCH, 1'b1}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (table_q[i]) send_op(table_q[i]);

    // random phases, each under its own grid setting
    foreach (grids[p]) begin
      drain();
      write_grid(grids[p][0], grids[p][1], grids[p][2]);
      for (int k = 0; k < 24; k++) begin
        row = rand_row();
        send_op(row);
      end
    end

    drain();
    $display("covered %0d operations (%0d queries), %0d results, 7 grid settings",
             items_sent, queries_sent, results_got);
    if (errors == 0) begin
      $display("uniform_grid_neighbor_query_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("uniform_grid_neighbor_query_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[uniform_grid_neighbor_query_unit.f]
src/ugnq_pkg.sv
src/uniform_grid_neighbor_query_unit.sv
verif/uniform_grid_neighbor_query_unit_tb.sv
